// ----- hdl/piea_pkg.sv -----
package piea_pkg;

   localparam int DEPTH_DEF  = 16;
   localparam int ELEM_W_DEF = 32;

   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // widest element the value path handles
   localparam int ELEM_W_MAX = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_RESIZE = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   // what every cell of the row does in the current cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ERASE  = 2'd2,
      CELL_FILL   = 2'd3
   } cell_op_type;

endpackage

// ----- hdl/piea_cell.sv -----
module piea_cell
   import piea_pkg::*;
#(
   parameter int ELEM_W = ELEM_W_DEF,
   parameter int POS    = 0,
   parameter int CMP_W  = 6
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [CMP_W-1:0]  idx,
   input  logic [CMP_W-1:0]  cnt,
   input  logic [ELEM_W-1:0] value,
   input  logic [ELEM_W-1:0] prev_entry,
   input  logic [ELEM_W-1:0] next_entry,
   output logic [ELEM_W-1:0] entry,
   output logic [ELEM_W-1:0] sel_entry
);

   localparam logic [CMP_W-1:0] POS_X  = CMP_W'(POS);
   localparam logic [CMP_W-1:0] NEXT_X = CMP_W'(POS + 1);

   logic [ELEM_W-1:0] entry_ff;
   logic [ELEM_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (op)
         CELL_INSERT: begin
            if (POS_X == idx) begin
               entry_in = value;
            end else if (POS_X > idx && POS_X <= cnt) begin
               entry_in = prev_entry;
            end
         end
         CELL_ERASE: begin
            if (POS_X >= idx && NEXT_X < cnt) begin
               entry_in = next_entry;
            end
         end
         CELL_FILL: begin
            if (POS_X >= cnt && POS_X < idx) begin
               entry_in = value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   // masked so the top can OR all cells together for a read
   assign sel_entry = (POS_X == idx) ? entry_ff : '0;

endmodule

// ----- hdl/positional_insert_erase_array_top.sv -----
// A command accepted at a clock edge has its result on the rsp_ ports during the
// next cycle, strobed by rsp_valid for exactly that cycle.
// Throughput: one command per cycle; every cell of the row shifts in the same
// cycle, so insert and erase cost no more than push or read. busy drops in the cycle
// after reset is released and stays low; the receiver cannot stall. Reset clears
// the count and holds busy high through the cycle after reset; entries are kept.
module positional_insert_erase_array_top
   import piea_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ELEM_W = ELEM_W_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

   logic              busy_ff;
   logic              accept;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_read_value_ff;
   logic [VALUE_W-1:0] rsp_read_value_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;
   status_type        rsp_status_ff;
   status_type        status;

   logic [CMP_W-1:0]  idx_x;
   logic [CMP_W-1:0]  cnt_x;
   logic [CMP_W-1:0]  cnt_next_x;
   logic [ELEM_W_MAX-1:0] value_x;
   logic [ELEM_W-1:0] elem;
   logic [ELEM_W_MAX-1:0] rd_x;
   logic [ELEM_W-1:0] rd_elem;
   logic              rd_hit;
   cell_op_type       op;
   cell_op_type       cell_op;

   logic [ELEM_W-1:0] entries [DEPTH];
   logic [ELEM_W-1:0] sel_entries [DEPTH];

   assign accept  = start && !busy_ff;
   assign idx_x   = CMP_W'(req_index);
   assign cnt_x   = CMP_W'(count_ff);
   assign value_x = ELEM_W_MAX'(req_value);
   assign elem    = value_x[ELEM_W-1:0];

   always_comb begin
      status     = ST_OK;
      cnt_next_x = cnt_x;
      op         = CELL_HOLD;
      rd_hit     = 1'b0;
      case (cmd_type'(req_cmd))
         CMD_PUSH: begin
            if (cnt_x >= DEPTH_X) begin
               status = ST_FULL;
            end else begin
               op         = CELL_INSERT;
               cnt_next_x = cnt_x + CMP_W'(1);
            end
         end
         CMD_POP: begin
            if (cnt_x == '0) begin
               status = ST_EMPTY;
            end else begin
               cnt_next_x = cnt_x - CMP_W'(1);
            end
         end
         CMD_INSERT: begin
            if (idx_x > cnt_x) begin
               status = ST_BAD;
            end else if (cnt_x >= DEPTH_X) begin
               status = ST_FULL;
            end else begin
               op         = CELL_INSERT;
               cnt_next_x = cnt_x + CMP_W'(1);
            end
         end
         CMD_ERASE: begin
            if (cnt_x == '0) begin
               status = ST_EMPTY;
            end else if (idx_x >= cnt_x) begin
               status = ST_BAD;
            end else begin
               op         = CELL_ERASE;
               cnt_next_x = cnt_x - CMP_W'(1);
            end
         end
         CMD_READ: begin
            if (cnt_x == '0) begin
               status = ST_EMPTY;
            end else if (idx_x >= cnt_x) begin
               status = ST_BAD;
            end else begin
               rd_hit = 1'b1;
            end
         end
         CMD_RESIZE: begin
            if (idx_x > DEPTH_X) begin
               status = ST_BAD;
            end else begin
               op         = CELL_FILL;
               cnt_next_x = idx_x;
            end
         end
         default: begin
            status = ST_BAD;
         end
      endcase
   end

   // push is an insert at the current count
   logic [CMP_W-1:0] cell_idx;
   assign cell_idx = (cmd_type'(req_cmd) == CMD_PUSH) ? cnt_x : idx_x;
   assign cell_op  = accept ? op : CELL_HOLD;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEM_W-1:0] prev_entry;
      logic [ELEM_W-1:0] next_entry;
      if (g == 0) begin : g_first
         assign prev_entry = elem;
      end else begin : g_prev
         assign prev_entry = entries[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_entry = elem;
      end else begin : g_next
         assign next_entry = entries[g+1];
      end
      piea_cell #(
         .ELEM_W (ELEM_W),
         .POS    (g),
         .CMP_W  (CMP_W)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .idx        (cell_idx),
         .cnt        (cnt_x),
         .value      (elem),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[g]),
         .sel_entry  (sel_entries[g])
      );
   end

   always_comb begin
      rd_elem = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_elem = rd_elem | sel_entries[i];
      end
   end

   assign rd_x              = ELEM_W_MAX'(rd_elem);
   assign rsp_read_value_in = rd_hit ? rd_x[VALUE_W-1:0] : '0;
   assign rsp_count_in      = cnt_next_x[COUNT_W-1:0];
   assign count_in          = accept ? cnt_next_x[CNT_W-1:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_count_ff      <= rsp_count_in;
         rsp_status_ff     <= status;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count exceeds capacity");

   a_one_result_per_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item gave no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid_ff)
      else $error("result without an item");

   a_failure_keeps_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> count_ff == $past(count_ff))
      else $error("failed command changed the count");

   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && cmd_type'(req_cmd) == CMD_READ |=> count_ff == $past(count_ff))
      else $error("read changed the count");

endmodule

// ----- verif/positional_insert_erase_array_top_tb.sv -----
`timescale 1ns / 1ps

module positional_insert_erase_array_top_tb;
   import piea_pkg::*;

   localparam int ARRAY_DEPTH    = DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;

   // command codes the block does not define
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   localparam logic [VALUE_W-1:0] VAL_ONES  = '1;
   localparam logic [VALUE_W-1:0] VAL_ZERO  = '0;
   localparam logic [VALUE_W-1:0] VAL_CHECK = 32'hA5A5_A5A5;
   localparam logic [VALUE_W-1:0] VAL_FILL  = 32'h5A5A_5A5A;

   typedef struct {
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } array_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd   = '0;
   logic [INDEX_W-1:0]  req_index = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic [COUNT_W-1:0]  rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   // shadow copy of the store
   logic [VALUE_W-1:0] shadow_entries [ARRAY_DEPTH];
   int                 shadow_count = 0;

   array_result_type expected_results [$];
   int               mismatch_count = 0;
   int               stall_cycles   = 0;
   bit               gaps_enabled   = 1'b1;

   positional_insert_erase_array_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic array_result_type apply_to_shadow(logic [CMD_W-1:0] cmd,
                                                        logic [INDEX_W-1:0] idx,
                                                        logic [VALUE_W-1:0] val);
      array_result_type res;
      int               i;
      res.read_value = '0;
      res.status     = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (shadow_count >= ARRAY_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               shadow_count--;
            end
         end
         CMD_INSERT: begin
            if (int'(idx) > shadow_count) begin
               res.status = ST_BAD;
            end else if (shadow_count >= ARRAY_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > int'(idx); i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[idx] = val;
               shadow_count++;
            end
         end
         CMD_ERASE: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (int'(idx) >= shadow_count) begin
               res.status = ST_BAD;
            end else begin
               for (i = int'(idx) + 1; i < shadow_count; i++)
                  shadow_entries[i-1] = shadow_entries[i];
               shadow_count--;
            end
         end
         CMD_READ: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (int'(idx) >= shadow_count) begin
               res.status = ST_BAD;
            end else begin
               res.read_value = shadow_entries[idx];
            end
         end
         CMD_RESIZE: begin
            if (int'(idx) > ARRAY_DEPTH) begin
               res.status = ST_BAD;
            end else begin
               // growth fills the new tail, truncation just drops it
               for (i = shadow_count; i < int'(idx); i++)
                  shadow_entries[i] = val;
               shadow_count = int'(idx);
            end
         end
         default: begin
            res.status = ST_BAD;
         end
      endcase
      res.count = shadow_count[COUNT_W-1:0];
      return res;
   endfunction

   // drive one item, hold it until accepted, then record what it should return
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                            logic [VALUE_W-1:0] val);
      array_result_type exp_res;
      if (gaps_enabled && $urandom_range(99, 0) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      exp_res          = apply_to_shadow(cmd, idx, val);
      expected_results = {expected_results, exp_res};
   endtask

   task automatic test_empty_store();
      gaps_enabled = 1'b1;
      send_item(CMD_POP,      5'd0,  VAL_ZERO);
      send_item(CMD_ERASE,    5'd0,  VAL_ZERO);
      send_item(CMD_READ,     5'd0,  VAL_ZERO);
      send_item(CMD_INSERT,   5'd1,  VAL_ONES);
      send_item(CMD_RESIZE,   5'd17, VAL_ONES);
      send_item(CMD_UNUSED_6, 5'd31, VAL_ONES);
      send_item(CMD_UNUSED_7, 5'd0,  VAL_ZERO);
   endtask

   task automatic test_basic_edit();
      send_item(CMD_PUSH,   5'd0,  VAL_ONES);
      send_item(CMD_PUSH,   5'd31, VAL_ZERO);
      send_item(CMD_INSERT, 5'd0,  VAL_CHECK);
      // index equal to the count appends
      send_item(CMD_INSERT, 5'd3,  ~VAL_CHECK);
      send_item(CMD_READ,   5'd3,  VAL_ONES);
      send_item(CMD_ERASE,  5'd1,  VAL_ONES);
      send_item(CMD_READ,   5'd3,  VAL_ZERO);
      send_item(CMD_ERASE,  5'd31, VAL_ZERO);
      send_item(CMD_READ,   5'd31, VAL_ZERO);
   endtask

   task automatic test_full_store();
      send_item(CMD_RESIZE, 5'd16, VAL_FILL);
      send_item(CMD_PUSH,   5'd0,  VAL_ONES);
      send_item(CMD_INSERT, 5'd0,  VAL_ONES);
      send_item(CMD_INSERT, 5'd17, VAL_ONES);
      send_item(CMD_RESIZE, 5'd16, VAL_ONES);
      send_item(CMD_READ,   5'd15, VAL_ZERO);
      send_item(CMD_RESIZE, 5'd0,  VAL_ONES);
      send_item(CMD_RESIZE, 5'd31, VAL_ZERO);
   endtask

   // mostly legal edits, reads and resizes that walk the count toward a moving target,
   // plus out-of-range indexes and unknown commands
   task automatic test_random_traffic(int n_items, bit with_gaps);
      int                 n;
      int                 pick;
      int                 fill_target;
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      gaps_enabled = with_gaps;
      fill_target  = $urandom_range(ARRAY_DEPTH, 0);
      for (n = 0; n < n_items; n++) begin
         if (n % 30 == 0)
            fill_target = $urandom_range(ARRAY_DEPTH, 0);
         pick = $urandom_range(99, 0);
         if (pick < 3)
            cmd = CMD_W'($urandom_range(CMD_UNUSED_7, CMD_UNUSED_6));
         else if (pick < 28)
            cmd = CMD_READ;
         else if (pick < 36)
            cmd = CMD_RESIZE;
         else if (pick < 68) begin
            if (shadow_count < fill_target)
               cmd = $urandom_range(1, 0) ? CMD_PUSH : CMD_INSERT;
            else
               cmd = $urandom_range(1, 0) ? CMD_POP : CMD_ERASE;
         end else if (pick < 84)
            cmd = $urandom_range(1, 0) ? CMD_PUSH : CMD_INSERT;
         else
            cmd = $urandom_range(1, 0) ? CMD_POP : CMD_ERASE;

         if ($urandom_range(99, 0) < 20)
            idx = INDEX_W'($urandom_range(31, 0));
         else if (cmd == CMD_INSERT)
            idx = INDEX_W'($urandom_range(shadow_count, 0));
         else if (cmd == CMD_RESIZE)
            idx = INDEX_W'($urandom_range(ARRAY_DEPTH, 0));
         else
            idx = INDEX_W'($urandom_range(shadow_count == 0 ? 0 : shadow_count - 1, 0));

         pick = $urandom_range(9, 0);
         if (pick == 0)
            val = VAL_ONES;
         else if (pick == 1)
            val = VAL_ZERO;
         else
            val = $urandom;
         send_item(cmd, idx, val);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_basic_edit();
      test_full_store();
      test_random_traffic(700, 1'b1);
      test_random_traffic(500, 1'b0);
      test_random_traffic(700, 1'b1);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      array_result_type want;
      if (rsp_valid === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with no item pending: value %h count %0d status %0d",
                     $time, rsp_read_value, rsp_count, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule
